// ===== rtl/core/swr_pkg.sv =====
// Shared types and constants for the stop-and-wait receiver.
`default_nettype none

package swr_pkg;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_DATA   = 2'd1,
        PH_CLOSED = 2'd2
    } phase_t;

    localparam logic [1:0] RTYPE_DATA = 2'd0;
    localparam logic [1:0] RTYPE_SYN  = 2'd1;
    localparam logic [1:0] RTYPE_FIN  = 2'd2;

    localparam logic [7:0] HTYPE_SYN = 8'd1;
    localparam logic [7:0] HTYPE_FIN = 8'd2;

    localparam logic [15:0] SUM_GOOD = 16'hFFFF;
    localparam int          HDR_LEN  = 8;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic [7:0] seq;
        logic [7:0] ack;
        logic       flag;
        logic [1:0] rtype;
    } reply_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic       packet_accepted;
        logic       reply_valid;
        reply_t     reply;
        logic       file_done;
        logic [1:0] session_phase;
        logic       length_error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/swr_core.sv =====
// Header parse, checksum fold and session decisions, one byte per cycle while in_fire is high.
`default_nettype none

module swr_core #(
    parameter int MAX_DATAGRAM = 16384
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output swr_pkg::result_t res_first,
    output swr_pkg::result_t res_second,
    output logic [1:0]      res_count
);
    import swr_pkg::*;

    localparam int POS_W = $clog2(MAX_DATAGRAM + 2);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DATAGRAM);
    localparam logic [POS_W-1:0] POS_OVER  = POS_W'(MAX_DATAGRAM + 1);

    localparam logic [16:0] P_SEQ    = 17'd0;
    localparam logic [16:0] P_ACK    = 17'd1;
    localparam logic [16:0] P_TYPE   = 17'd3;
    localparam logic [16:0] P_LEN_HI = 17'd4;
    localparam logic [16:0] P_LEN_LO = 17'd5;
    localparam logic [16:0] P_HDR    = 17'(HDR_LEN);

    phase_t           phase_reg, phase_next;
    logic [7:0]       exp_seq_reg, exp_seq_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      dlen_reg, dlen_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       hseq_reg, hseq_next;
    logic [7:0]       hack_reg, hack_next;
    logic [7:0]       htype_reg, htype_next;
    reply_t           last_reply_reg, last_reply_next;

    function automatic logic [15:0] fold(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    always_comb begin
        logic [16:0] p_ext;
        logic [16:0] span;
        logic [16:0] count;
        logic [16:0] inc;
        logic        in_range;
        logic        is_data;
        logic        in_span;
        logic        step_fold;
        logic        end_fold;
        logic        over;
        logic        valid;
        logic        send;
        logic        accepted;
        logic        fdone;
        logic        payload;
        logic [15:0] word;
        logic [15:0] sum_w;
        logic [7:0]  seq_inc;
        reply_t      rep;
        result_t     rpt;
        result_t     pl;

        phase_next      = phase_reg;
        exp_seq_next    = exp_seq_reg;
        last_reply_next = last_reply_reg;
        hseq_next       = hseq_reg;
        hack_next       = hack_reg;
        htype_next      = htype_reg;
        dlen_next       = dlen_reg;
        rep             = '0;
        send            = 1'b0;
        accepted        = 1'b0;
        fdone           = 1'b0;
        rpt             = '0;
        pl              = '0;

        p_ext    = 17'(pos_reg);
        in_range = pos_reg < POS_LIMIT;

        if (in_range) begin
            unique case (p_ext)
                P_SEQ:    hseq_next  = in_byte;
                P_ACK:    hack_next  = in_byte;
                P_TYPE:   htype_next = in_byte;
                P_LEN_HI: dlen_next  = {in_byte, 8'd0};
                P_LEN_LO: dlen_next  = {dlen_reg[15:8], in_byte};
                default:  ;
            endcase
        end

        is_data = htype_next != HTYPE_SYN && htype_next != HTYPE_FIN;
        span    = (phase_reg == PH_DATA && is_data) ? P_HDR + 17'(dlen_next) : P_HDR;
        in_span = in_range && p_ext < span;

        step_fold = in_span && p_ext[0];
        pend_next = (in_span && !p_ext[0]) ? in_byte : pend_reg;
        pos_next  = in_range ? pos_reg + POS_W'(1) : POS_OVER;

        payload = phase_reg == PH_DATA && in_range && p_ext >= P_HDR &&
                  p_ext < P_HDR + 17'(dlen_next) && is_data && hseq_next == exp_seq_reg;

        count = 17'(pos_next);
        over  = pos_next > POS_LIMIT;
        inc   = (count < span) ? count : span;
        // odd span: pad the last high byte with zero; never coincides with a step fold
        end_fold = in_last && !over && phase_reg != PH_CLOSED && inc[0];

        word     = step_fold ? {pend_reg, in_byte} : {pend_next, 8'd0};
        sum_w    = fold(sum_reg, word);
        sum_next = (step_fold || end_fold) ? sum_w : sum_reg;
        valid    = sum_next == SUM_GOOD;
        seq_inc  = hseq_next + 8'd1;

        if (in_last && !over) begin
            unique case (phase_reg)
                PH_WAIT: begin
                    if (htype_next == HTYPE_SYN && valid) begin
                        rep             = '{seq: hseq_next, ack: seq_inc, flag: 1'b1,
                                            rtype: RTYPE_SYN};
                        send            = 1'b1;
                        phase_next      = PH_DATA;
                        exp_seq_next    = 8'd0;
                        last_reply_next = '0;
                    end else begin
                        phase_next = PH_CLOSED;
                    end
                end
                PH_DATA: begin
                    if (htype_next == HTYPE_FIN) begin
                        if (valid) begin
                            rep  = '{seq: hseq_next, ack: seq_inc, flag: 1'b1,
                                     rtype: RTYPE_FIN};
                            send = 1'b1;
                        end
                        phase_next = PH_CLOSED;
                    end else if (is_data && hseq_next == exp_seq_reg) begin
                        if (valid) begin
                            rep             = '{seq: seq_inc, ack: hack_next, flag: 1'b1,
                                                rtype: RTYPE_DATA};
                            send            = 1'b1;
                            accepted        = 1'b1;
                            last_reply_next = rep;
                            fdone           = hack_next == 8'd0;
                            exp_seq_next    = fdone ? 8'd0 : seq_inc;
                        end
                    end else begin
                        // out of sequence or stray SYN: resend the last reply
                        rep  = last_reply_reg;
                        send = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        rpt.result_kind     = 1'b1;
        rpt.length_error    = over;
        rpt.packet_accepted = accepted;
        rpt.file_done       = fdone;
        rpt.reply_valid     = send;
        rpt.reply           = rep;
        rpt.session_phase   = phase_next;

        pl.payload_byte = in_byte;

        if (payload) begin
            res_first  = pl;
            res_second = rpt;
            res_count  = in_last ? 2'd2 : 2'd1;
        end else begin
            res_first  = rpt;
            res_second = '0;
            res_count  = in_last ? 2'd1 : 2'd0;
        end

        // drop all per-datagram state after the report
        if (in_last) begin
            pos_next   = '0;
            dlen_next  = '0;
            sum_next   = '0;
            pend_next  = '0;
            hseq_next  = '0;
            hack_next  = '0;
            htype_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            exp_seq_reg    <= '0;
            pos_reg        <= '0;
            dlen_reg       <= '0;
            sum_reg        <= '0;
            pend_reg       <= '0;
            hseq_reg       <= '0;
            hack_reg       <= '0;
            htype_reg      <= '0;
            last_reply_reg <= '0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            exp_seq_reg    <= exp_seq_next;
            pos_reg        <= pos_next;
            dlen_reg       <= dlen_next;
            sum_reg        <= sum_next;
            pend_reg       <= pend_next;
            hseq_reg       <= hseq_next;
            hack_reg       <= hack_next;
            htype_reg      <= htype_next;
            last_reply_reg <= last_reply_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/swr_fifo.sv =====
// Small result queue: takes up to two words a cycle, hands out one.
`default_nettype none

module swr_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_count,
    input  swr_pkg::result_t push_first,
    input  swr_pkg::result_t push_second,
    input  logic             pop,
    output swr_pkg::result_t head,
    output logic             not_empty,
    output logic             room_for_two
);
    import swr_pkg::*;

    result_t                mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_PTR_W:0]     level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        level_next  = level_reg + (OUT_PTR_W + 1)'(push_count) - (OUT_PTR_W + 1)'(pop);
    end

    assign head         = mem[rd_ptr_reg];
    assign not_empty    = level_reg != '0;
    assign room_for_two = level_reg <= (OUT_PTR_W + 1)'(OUT_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_reg + OUT_PTR_W'(1)] <= push_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stop_and_wait_receiver_unit.sv =====
// Top level of the stop-and-wait receiver.
// Takes one datagram byte per cycle, tlast on the final byte. Each byte sits in an input
// register until it can move on, then the parser updates header fields, position and the
// one's-complement checksum and writes its results into a four-word output queue. A data
// payload byte gives one word (tuser 0) at once; the final byte gives the end-of-datagram
// report (tuser 1), after the payload word when that byte is payload too. Sustained rate is
// one byte per cycle while the sink takes one word per cycle; the only other limit is the
// output queue, which must have two free words before a byte moves on from the input
// register.
`default_nettype none

module stop_and_wait_receiver_unit #(
    parameter int MAX_DATAGRAM = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [8] packet_accepted, [9] reply_valid, [17:10] reply_seq,
    // [25:18] reply_ack, [26] reply_ack_flag, [28:27] reply_type, [29] file_done,
    // [31:30] session_phase, [32] length_error, [39:33] zero
    output logic [39:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser    // [0] result_kind
);
    import swr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       proc_fire;
    logic       room_for_two;
    logic [1:0] res_count;
    logic [1:0] push_count;
    result_t    res_first;
    result_t    res_second;
    result_t    head;

    assign proc_fire     = in_valid_reg && room_for_two;
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign push_count    = proc_fire ? res_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    swr_core #(
        .MAX_DATAGRAM(MAX_DATAGRAM)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (proc_fire),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res_first (res_first),
        .res_second(res_second),
        .res_count (res_count)
    );

    swr_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (push_count),
        .push_first  (res_first),
        .push_second (res_second),
        .pop         (m_axis_tvalid && m_axis_tready),
        .head        (head),
        .not_empty   (m_axis_tvalid),
        .room_for_two(room_for_two)
    );

    assign m_axis_tuser = head.result_kind;
    assign m_axis_tdata = {7'd0, head.length_error, head.session_phase, head.file_done,
                           head.reply.rtype, head.reply.flag, head.reply.ack,
                           head.reply.seq, head.reply_valid, head.packet_accepted,
                           head.payload_byte};

endmodule

`default_nettype wire

// ===== test/stop_and_wait_receiver_unit_tb.sv =====
// Randomized self-checking testbench for the stop-and-wait receiver unit.
`timescale 1ns / 100ps

import swr_pkg::*;

// Mirror of the receiver: tracks session and datagram state and queues the words it owes.
class arq_mirror #(int MAXD = 16384);
    result_t     due_words[$];
    int          words_seen;
    int          errors;
    phase_t      phase;
    logic [7:0]  exp_seq;
    int          pos;
    logic [15:0] decl_len;
    logic [15:0] sum;
    logic [7:0]  hi_byte;
    logic [7:0]  h_seq;
    logic [7:0]  h_ack;
    logic [7:0]  h_type;
    reply_t      last_reply;

    function new();
        phase      = PH_WAIT;
        exp_seq    = 8'd0;
        last_reply = '0;
        words_seen = 0;
        errors     = 0;
        clear_dg();
    endfunction

    function void clear_dg();
        pos      = 0;
        decl_len = 16'd0;
        sum      = 16'd0;
        hi_byte  = 8'd0;
        h_seq    = 8'd0;
        h_ack    = 8'd0;
        h_type   = 8'd0;
    endfunction

    // One's-complement add with end-around carry.
    function logic [15:0] add16(logic [15:0] a, logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        if (s[16]) begin
            s = {1'b0, s[15:0]} + 17'd1;
        end
        return s[15:0];
    endfunction

    function bit data_type();
        return h_type != HTYPE_SYN && h_type != HTYPE_FIN;
    endfunction

    function int span();
        if (phase == PH_DATA && data_type()) begin
            return HDR_LEN + decl_len;
        end
        return HDR_LEN;
    endfunction

    function int pending();
        return due_words.size();
    endfunction

    function reply_t mk_reply(logic [7:0] s, logic [7:0] a, logic [1:0] t);
        reply_t rp;
        rp.seq   = s;
        rp.ack   = a;
        rp.flag  = 1'b1;
        rp.rtype = t;
        return rp;
    endfunction

    function void take_byte(logic [7:0] b, logic lst);
        result_t r;
        reply_t  rep;
        int      p;
        int      inc;
        bit      ok;
        bit      send;
        p = pos;
        if (p < MAXD) begin
            case (p)
                0: h_seq = b;
                1: h_ack = b;
                3: h_type = b;
                4: decl_len = {b, 8'h00};
                5: decl_len = decl_len | {8'h00, b};
                default: ;
            endcase
            if (p < span()) begin
                if (p % 2 == 0) begin
                    hi_byte = b;
                end else begin
                    sum = add16(sum, {hi_byte, b});
                end
            end
            if (phase == PH_DATA && p >= HDR_LEN && p < HDR_LEN + decl_len && data_type()
                && h_seq == exp_seq) begin
                r = '0;
                r.payload_byte = b;
                due_words.push_back(r);
            end
            pos = p + 1;
        end else begin
            pos = MAXD + 1;
        end
        if (!lst) return;

        r = '0;
        r.result_kind = 1'b1;
        rep  = '0;
        send = 1'b0;
        if (pos > MAXD) begin
            r.length_error = 1'b1;
        end else if (phase != PH_CLOSED) begin
            inc = (pos < span()) ? pos : span();
            // pad an odd trailing byte with a zero low half
            if (inc % 2 == 1) begin
                sum = add16(sum, {hi_byte, 8'h00});
            end
            ok = (sum == SUM_GOOD);
            if (phase == PH_WAIT) begin
                if (h_type == HTYPE_SYN && ok) begin
                    rep        = mk_reply(h_seq, h_seq + 8'd1, RTYPE_SYN);
                    send       = 1'b1;
                    phase      = PH_DATA;
                    exp_seq    = 8'd0;
                    last_reply = '0;
                end else begin
                    phase = PH_CLOSED;
                end
            end else if (h_type == HTYPE_FIN) begin
                if (ok) begin
                    rep  = mk_reply(h_seq, h_seq + 8'd1, RTYPE_FIN);
                    send = 1'b1;
                end
                phase = PH_CLOSED;
            end else if (data_type() && h_seq == exp_seq) begin
                if (ok) begin
                    exp_seq           = h_seq + 8'd1;
                    rep               = mk_reply(exp_seq, h_ack, RTYPE_DATA);
                    last_reply        = rep;
                    send              = 1'b1;
                    r.packet_accepted = 1'b1;
                    if (h_ack == 8'd0) begin
                        r.file_done = 1'b1;
                        exp_seq     = 8'd0;
                    end
                end
            end else begin
                // out of sequence or stray SYN: repeat the previous answer
                rep  = last_reply;
                send = 1'b1;
            end
            if (send) begin
                r.reply_valid = 1'b1;
                r.reply       = rep;
            end
        end
        r.session_phase = phase;
        due_words.push_back(r);
        clear_dg();
    endfunction

    function void check_field(string name, int unsigned ex, int unsigned ac);
        if (ex != ac) begin
            $display("%0t: %s expected %0h got %0h", $time, name, ex, ac);
            errors++;
        end
    endfunction

    function void match_word(logic [39:0] d, logic [0:0] u);
        result_t e;
        words_seen++;
        if (due_words.size() == 0) begin
            $display("%0t: unexpected word, tuser %h tdata %h", $time, u, d);
            errors++;
            return;
        end
        e = due_words.pop_front();
        check_field("result_kind", e.result_kind, u[0]);
        check_field("payload_byte", e.payload_byte, d[7:0]);
        check_field("packet_accepted", e.packet_accepted, d[8]);
        check_field("reply_valid", e.reply_valid, d[9]);
        check_field("reply_seq", e.reply.seq, d[17:10]);
        check_field("reply_ack", e.reply.ack, d[25:18]);
        check_field("reply_ack_flag", e.reply.flag, d[26]);
        check_field("reply_type", e.reply.rtype, d[28:27]);
        check_field("file_done", e.file_done, d[29]);
        check_field("session_phase", e.session_phase, d[31:30]);
        check_field("length_error", e.length_error, d[32]);
        check_field("tdata padding", 0, d[39:33]);
    endfunction
endclass

module stop_and_wait_receiver_unit_tb;

    localparam int MAX_DG      = 16384;
    localparam int ITEMS       = 1650;
    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    arq_mirror #(MAX_DG) sb;
    logic [7:0]          dg[$];
    int                  burst_left = 0;
    int                  cycles     = 0;

    stop_and_wait_receiver_unit #(
        .MAX_DATAGRAM(MAX_DG)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.match_word(m_axis_tdata, m_axis_tuser);
        end
    end

    // Sink: the stall pattern is re-picked at random among four modes; one long hold-off once traffic is going.
    initial begin
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 50 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (!held && sb.words_seen >= 400) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                held = 1'b1;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (cyc % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Enter at a falling edge, leave at the falling edge after the word is taken.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do @(posedge aclk); while (!s_axis_tready);
        sb.take_byte(b, lst);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_dg();
        int i;
        for (i = 0; i < dg.size(); i++) begin
            send_byte(dg[i], i == dg.size() - 1);
        end
    endtask

    function automatic void compose(input logic [7:0] seq, input logic [7:0] ack,
                                    input logic [7:0] flag, input logic [7:0] typ,
                                    input logic [15:0] len, input int npay);
        int i;
        dg.delete();
        dg.push_back(seq);
        dg.push_back(ack);
        dg.push_back(flag);
        dg.push_back(typ);
        dg.push_back(len[15:8]);
        dg.push_back(len[7:0]);
        dg.push_back(8'h00);
        dg.push_back(8'h00);
        for (i = 0; i < npay; i++) begin
            dg.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Trim or extend with random bytes.
    function automatic void fit(input int total);
        while (dg.size() > total) dg.pop_back();
        while (dg.size() < total) dg.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Fill in the checksum over the span, missing bytes as zero; optionally flip one bit.
    function automatic void seal(input int spn, input bit corrupt);
        logic [15:0] s;
        logic [15:0] w;
        int          lim;
        int          i;
        int          idx;
        lim = (spn < dg.size()) ? spn : dg.size();
        s   = 16'd0;
        for (i = 0; i < lim; i += 2) begin
            w = {dg[i], (i + 1 < lim) ? dg[i + 1] : 8'h00};
            s = sb.add16(s, w);
        end
        s = ~s;
        if (dg.size() > 6) dg[6] = s[15:8];
        if (dg.size() > 7) dg[7] = s[7:0];
        if (corrupt && lim > 0) begin
            idx = $urandom_range(0, lim - 1);
            // keep the type byte so a flip cannot turn a packet into a FIN
            if (idx == 3) idx = 2;
            dg[idx] = dg[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
    endfunction

    initial begin
        int         k;
        int         nbytes;
        int         r;
        int         len;
        int         total;
        int         shape;
        int         spn;
        bit         bad;
        logic [7:0] seq;
        logic [7:0] ack;
        logic [7:0] typ;

        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // handshake with seq at the top of its range, so the answer wraps to zero
        compose(8'hFF, 8'h00, 8'h00, HTYPE_SYN, 16'd0, 0);
        seal(HDR_LEN, 1'b0);
        send_dg();
        // one-byte payload of all ones, ack zero closes the file, odd span
        compose(8'h00, 8'h00, 8'h01, 8'h00, 16'd1, 1);
        dg[8] = 8'hFF;
        seal(HDR_LEN + 1, 1'b0);
        send_dg();
        // header cut short after three bytes
        dg = '{8'h00, 8'hFF, 8'h80};
        send_dg();
        nbytes = 20;

        k = 0;
        while (nbytes < ITEMS) begin
            if (k == 40) begin
                // drain completely before going on
                s_axis_tvalid <= 1'b0;
                do @(negedge aclk); while (sb.pending() != 0);
                burst_left = 0;
            end
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                              : $urandom_range(0, 24);
            typ = ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(3, 255));
            ack = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            seq = sb.exp_seq;
            bad = 1'b0;
            if (r < 70) begin
                bad = (r >= 55);
            end else if (r < 85) begin
                seq = sb.exp_seq + 8'($urandom_range(1, 255));
                bad = ($urandom_range(0, 4) == 0);
            end else if (r < 93) begin
                typ = HTYPE_SYN;
                seq = 8'($urandom_range(0, 255));
                bad = 1'($urandom_range(0, 1));
            end
            if (r < 93) begin
                compose(seq, ack, 8'($urandom_range(0, 255)), typ, 16'(len), len);
                spn   = (typ == HTYPE_SYN) ? HDR_LEN : HDR_LEN + len;
                total = HDR_LEN + len;
                shape = $urandom_range(0, 11);
                if (shape == 0) begin
                    total = $urandom_range(1, HDR_LEN + len - 1);
                end else if (shape == 1) begin
                    total = total + $urandom_range(1, 4);
                end
                fit(total);
                seal(spn, bad);
            end else begin
                dg.delete();
                fit($urandom_range(1, 20));
                if (dg.size() > 3 && dg[3] == HTYPE_FIN) dg[3] = 8'd0;
            end
            send_dg();
            nbytes += dg.size();
            k++;
        end

        // close the session, then traffic that must be ignored
        compose(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd1, HTYPE_FIN,
                16'($urandom_range(0, 5)), 0);
        fit(HDR_LEN + $urandom_range(0, 2));
        seal(HDR_LEN, 1'($urandom_range(0, 1)));
        send_dg();
        repeat (3) begin
            dg.delete();
            fit($urandom_range(1, 12));
            send_dg();
        end

        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (10) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
